>>> hw/rtl/atti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atti_pkg
// Shared types and constants of the table temperature interpolator.
// ----------------------------------------------------------------------------
package atti_pkg;

    localparam int TEMP_W = 12;
    localparam int QUO_W  = 13;
    localparam int CFG_W  = 8;
    localparam int CH_W   = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd2;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic [CH_W-1:0] CH_TABLE_A = 3'd1;
    localparam logic [CH_W-1:0] CH_TABLE_B = 3'd2;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_TABLE = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LO   = 7'b0000010,
        S_HI   = 7'b0000100,
        S_SRCH = 7'b0001000,
        S_NBR  = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_DIV  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

>>> hw/rtl/atti_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module atti_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/atti_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atti_div
// Restoring divider, one quotient bit per cycle; quotient saturates to all
// ones when it does not fit in QUO_W bits.
// ----------------------------------------------------------------------------
module atti_div
    import atti_pkg::*;
#(
    parameter int NUM_W = 24,
    parameter int DEN_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quotient,
    output div_sts_t         sts
);

    localparam int W  = DEN_W + QUO_W;
    localparam int CW = $clog2(QUO_W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsh_reg, dsh_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic          ovf_reg, ovf_next;
    logic          ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (go)
        begin
            rem_next  = W'(num);
            dsh_next  = W'(den) << (QUO_W - 1);
            // quotient would need more than QUO_W bits
            ovf_next  = (W'(num) >= (W'(den) << QUO_W));
            q_next    = '0;
            cnt_next  = CW'(QUO_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[QUO_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign quotient = ovf_reg ? '1 : q_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

>>> hw/rtl/adc_table_temperature_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_table_temperature_interpolator_core
// Breakpoint-table ADC to temperature converter with linear interpolation.
// ----------------------------------------------------------------------------
// A write beat (opcode 0) stores one breakpoint and keeps busy low, so the
// next beat may follow at once. A convert beat on a channel without a table
// returns status 1 in the next cycle, also without raising busy. A convert
// beat on channel 1 or 2 holds busy through the end checks, the binary
// search (up to ceil(log2(entries)) + 1 probes), the neighbor read, the
// multiply and the division; samples that clamp to a table end or hit a
// breakpoint exactly finish earlier. The single registered table RAM port
// is read once for each end check and each probe, and the serial divider
// yields one of 13 quotient bits per cycle. Each result appears on
// temperature/status with done high for exactly one cycle; the receiver
// cannot stall, so it must take every done beat.
module adc_table_temperature_interpolator_core
    import atti_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           opcode,
    input  logic [$clog2(TABLE_DEPTH)-1:0] entry_index,
    input  logic [SAMPLE_BITS-1:0]         entry_code,
    input  logic signed [TEMP_W-1:0]       entry_temperature,
    input  logic [SAMPLE_BITS-1:0]         adc_sample,
    input  logic [CH_W-1:0]                channel,
    input  logic                           cfg_we,
    input  logic [CFG_W-1:0]               cfg_wdata,
    output logic                           done,
    output logic signed [TEMP_W-1:0]       temperature,
    output logic                           status
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SB    = SAMPLE_BITS;
    localparam int PRD_W = TEMP_W + SB;
    localparam int SUM_W = QUO_W + 2;

    state_t             state_reg, state_next;
    logic               done_reg, done_next;
    logic               div_go_reg, div_go_next;
    logic [CFG_W-1:0]   cfg_reg;
    logic [TEMP_W-1:0]  temp_reg, temp_next;
    logic               status_reg, status_next;
    logic [SB-1:0]      s_reg, s_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   low_reg, low_next;
    logic [CNT_W-1:0]   high_reg, high_next;
    logic [IDX_W-1:0]   mid_reg, mid_next;
    logic [SB-1:0]      cm_reg, cm_next;
    logic [TEMP_W-1:0]  tm_reg, tm_next;
    logic               below_reg, below_next;
    logic [SB-1:0]      den_reg, den_next;
    logic [SB-1:0]      dist_reg, dist_next;
    logic [TEMP_W-1:0]  dmag_reg, dmag_next;
    logic               neg_reg, neg_next;
    logic [PRD_W-1:0]   prod_reg;

    logic               accept;
    logic               idx_ok;
    logic               we;
    logic [IDX_W-1:0]   raddr;
    logic [SB+TEMP_W-1:0] rd_data;
    logic [SB-1:0]      rd_code;
    logic [TEMP_W-1:0]  rd_temp;
    logic [CNT_W-1:0]   n_clamp;
    logic [CNT_W-1:0]   last;
    logic [CNT_W-1:0]   last_half;

    logic [CNT_W-1:0]   mid_ext;
    logic               c_gt, c_lt;
    logic [CNT_W-1:0]   new_low, new_high;
    logic [CNT_W:0]     mid_sum;
    logic [CNT_W:0]     mid_half;
    logic               srch_exit;
    logic [CNT_W-1:0]   nb_up;
    logic [IDX_W-1:0]   nb_dn;
    logic               nb_ok;

    logic [SB:0]        den_dn, den_up, den_sel;
    logic               den_ok;
    logic [TEMP_W:0]    tdiff, tdiff_neg;

    logic [QUO_W-1:0]   quotient;
    div_sts_t           div_sts;
    logic [SUM_W-1:0]   tm_ext, q_ext, sum;
    logic               sum_fits;
    logic [TEMP_W-1:0]  sum_sat;

    assign accept = start && !busy;
    assign idx_ok = (32'(entry_index) < 32'(TABLE_DEPTH));
    assign we     = accept && (opcode == OP_WRITE) && idx_ok;

    atti_ram #(
        .WIDTH (SB + TEMP_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (entry_index),
        .wdata ({entry_code, entry_temperature}),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign rd_code = rd_data[SB+TEMP_W-1:TEMP_W];
    assign rd_temp = rd_data[TEMP_W-1:0];

    // entry count clamped to 2..TABLE_DEPTH
    always_comb
    begin
        if (cfg_reg < 8'd2)
        begin
            n_clamp = CNT_W'(2);
        end
        else if (32'(cfg_reg) > 32'(TABLE_DEPTH))
        begin
            n_clamp = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n_clamp = CNT_W'(cfg_reg);
        end
    end

    assign last      = n_reg - 1'b1;
    assign last_half = last >> 1;

    // search step on the probed entry
    assign mid_ext   = CNT_W'(mid_reg);
    assign c_gt      = (rd_code > s_reg);
    assign c_lt      = (rd_code < s_reg);
    assign new_low   = c_lt ? (mid_ext + 1'b1) : low_reg;
    assign new_high  = c_gt ? (mid_ext - 1'b1) : high_reg;
    assign mid_sum   = {1'b0, new_low} + {1'b0, new_high};
    assign mid_half  = mid_sum >> 1;
    assign srch_exit = (c_gt && (mid_reg == '0)) || (new_low > new_high);
    assign nb_up     = mid_ext + 1'b1;
    assign nb_dn     = mid_reg - 1'b1;
    assign nb_ok     = c_gt ? (mid_reg != '0) : (nb_up < n_reg);

    // neighbor entry: code gap and temperature step
    assign den_dn  = {1'b0, cm_reg} - {1'b0, rd_code};
    assign den_up  = {1'b0, rd_code} - {1'b0, cm_reg};
    assign den_sel = below_reg ? den_dn : den_up;
    assign den_ok  = !den_sel[SB] && (den_sel != '0);
    assign tdiff     = {rd_temp[TEMP_W-1], rd_temp} - {tm_reg[TEMP_W-1], tm_reg};
    assign tdiff_neg = -tdiff;

    atti_div #(
        .NUM_W (PRD_W),
        .DEN_W (SB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go_reg),
        .num      (prod_reg),
        .den      (den_reg),
        .quotient (quotient),
        .sts      (div_sts)
    );

    // final add and saturation to the temperature range
    assign tm_ext   = {{(SUM_W-TEMP_W){tm_reg[TEMP_W-1]}}, tm_reg};
    assign q_ext    = {{(SUM_W-QUO_W){1'b0}}, quotient};
    assign sum      = neg_reg ? (tm_ext - q_ext) : (tm_ext + q_ext);
    assign sum_fits = (&sum[SUM_W-1:TEMP_W-1]) || !(|sum[SUM_W-1:TEMP_W-1]);
    assign sum_sat  = sum_fits ? sum[TEMP_W-1:0] :
                      (sum[SUM_W-1] ? {1'b1, {(TEMP_W-1){1'b0}}} :
                                      {1'b0, {(TEMP_W-1){1'b1}}});

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        div_go_next = 1'b0;
        temp_next   = temp_reg;
        status_next = status_reg;
        s_next      = s_reg;
        n_next      = n_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        mid_next    = mid_reg;
        cm_next     = cm_reg;
        tm_next     = tm_reg;
        below_next  = below_reg;
        den_next    = den_reg;
        dist_next   = dist_reg;
        dmag_next   = dmag_reg;
        neg_next    = neg_reg;
        raddr       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && (opcode == OP_CONVERT))
                begin
                    if ((channel == CH_TABLE_A) || (channel == CH_TABLE_B))
                    begin
                        s_next     = adc_sample;
                        n_next     = n_clamp;
                        state_next = S_LO;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        temp_next   = '0;
                        status_next = STATUS_NO_TABLE;
                    end
                end
            end
            S_LO:
            begin
                if (s_reg <= rd_code)
                begin
                    done_next   = 1'b1;
                    temp_next   = rd_temp;
                    status_next = STATUS_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    raddr      = last[IDX_W-1:0];
                    state_next = S_HI;
                end
            end
            S_HI:
            begin
                if (s_reg >= rd_code)
                begin
                    done_next   = 1'b1;
                    temp_next   = rd_temp;
                    status_next = STATUS_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    low_next   = '0;
                    high_next  = last;
                    mid_next   = last_half[IDX_W-1:0];
                    raddr      = last_half[IDX_W-1:0];
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                cm_next = rd_code;
                tm_next = rd_temp;
                if (!c_gt && !c_lt)
                begin
                    // sample sits exactly on a breakpoint
                    done_next   = 1'b1;
                    temp_next   = rd_temp;
                    status_next = STATUS_OK;
                    state_next  = S_IDLE;
                end
                else if (srch_exit)
                begin
                    below_next = c_gt;
                    if (!nb_ok)
                    begin
                        done_next   = 1'b1;
                        temp_next   = rd_temp;
                        status_next = STATUS_OK;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        raddr      = c_gt ? nb_dn : nb_up[IDX_W-1:0];
                        state_next = S_NBR;
                    end
                end
                else
                begin
                    low_next  = new_low;
                    high_next = new_high;
                    mid_next  = mid_half[IDX_W-1:0];
                    raddr     = mid_half[IDX_W-1:0];
                end
            end
            S_NBR:
            begin
                if (!den_ok)
                begin
                    // broken table: no positive code gap to the neighbor
                    done_next   = 1'b1;
                    temp_next   = tm_reg;
                    status_next = STATUS_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    den_next   = den_sel[SB-1:0];
                    dist_next  = below_reg ? (cm_reg - s_reg) : (s_reg - cm_reg);
                    neg_next   = tdiff[TEMP_W];
                    dmag_next  = tdiff[TEMP_W] ? tdiff_neg[TEMP_W-1:0] : tdiff[TEMP_W-1:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                div_go_next = 1'b1;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                if (div_sts.done)
                begin
                    done_next   = 1'b1;
                    temp_next   = sum_sat;
                    status_next = STATUS_OK;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            div_go_reg <= 1'b0;
            cfg_reg    <= CFG_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            div_go_reg <= div_go_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        temp_reg   <= temp_next;
        status_reg <= status_next;
        s_reg      <= s_next;
        n_reg      <= n_next;
        low_reg    <= low_next;
        high_reg   <= high_next;
        mid_reg    <= mid_next;
        cm_reg     <= cm_next;
        tm_reg     <= tm_next;
        below_reg  <= below_next;
        den_reg    <= den_next;
        dist_reg   <= dist_next;
        dmag_reg   <= dmag_next;
        neg_reg    <= neg_next;
        prod_reg   <= dmag_reg * dist_reg;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign temperature = temp_reg;
    assign status      = status_reg;

    // a result beat only follows an accepted beat or work in progress
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start || busy))
        else $error("result beat without a cause");

    // the divider only runs while the sequencer waits for it
    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.busy |-> (state_reg == S_DIV))
        else $error("divider busy outside divide state");

    // a write beat never starts a conversion
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_WRITE)) |=> (!busy && !done))
        else $error("write beat caused activity");

    // no-table status always carries zero temperature
    a_no_table: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_NO_TABLE)) |-> (temperature == '0))
        else $error("no-table result with nonzero temperature");

endmodule
